// ===== hw/rtl/pid_keyed_probe_table_unit_defines.svh =====
// Assertion macros used by the back part of the probe table RTL.
`ifndef PID_KEYED_PROBE_TABLE_UNIT_DEFINES_SVH
`define PID_KEYED_PROBE_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define PKPT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define PKPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pkpt_pkg.sv =====
// Package with widths, codes and defaults of the probe table.
`default_nettype none
package pkpt_pkg;

  localparam int KEY_W           = 31;
  localparam int HANDLE_W        = 32;
  localparam int STATUS_W        = 2;
  localparam int SLOT_IDX_W      = 10;
  localparam int TAG_W           = 2;
  localparam int ENTRY_W         = TAG_W + KEY_W + HANDLE_W;
  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_BIND   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  localparam logic [TAG_W-1:0] TAG_EMPTY = 2'd0;
  localparam logic [TAG_W-1:0] TAG_LIVE  = 2'd1;
  localparam logic [TAG_W-1:0] TAG_TOMB  = 2'd2;

endpackage
`default_nettype wire

// ===== hw/rtl/pkpt_if.sv =====
// Request and response channel interfaces of the probe table.
`default_nettype none
interface pkpt_req_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [pkpt_pkg::KEY_W-1:0]    key;
  logic [pkpt_pkg::HANDLE_W-1:0] handle;

  modport source (output valid, command, key, handle, input ready);
  modport sink (input valid, command, key, handle, output ready);
endinterface

interface pkpt_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [pkpt_pkg::STATUS_W-1:0]   status;
  logic [pkpt_pkg::HANDLE_W-1:0]   found_handle;
  logic [pkpt_pkg::SLOT_IDX_W-1:0] slot_index;

  modport source (output valid, status, found_handle, slot_index, input ready);
  modport sink (input valid, status, found_handle, slot_index, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pkpt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pkpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pkpt_fifo.sv =====
// Small register queue between the front and back parts.
`default_nettype none
module pkpt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [WIDTH-1:0] in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [WIDTH-1:0] out_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != (PW + 1)'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= in_data;
        wr_ptr          <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pkpt_front.sv =====
// Front part: takes requests and reduces the key to its home slot.
`default_nettype none
module pkpt_front #(
  parameter int TABLE_DEPTH = pkpt_pkg::DEF_TABLE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  pkpt_req_if.sink   req,
  input  wire logic  clear_busy,
  output logic       push_valid,
  input  wire logic  push_ready,
  output logic [1 + pkpt_pkg::KEY_W + pkpt_pkg::HANDLE_W + $clog2(TABLE_DEPTH) - 1:0]
                     push_data
);

  localparam int KW  = pkpt_pkg::KEY_W;
  localparam int AW  = $clog2(TABLE_DEPTH);
  // Scaled reciprocal of the depth: bits RSH and up of key * RECIP are exactly
  // key / TABLE_DEPTH for every key of KW bits.
  localparam int RSH = KW + AW;
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << RSH) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH);
  localparam logic [KW:0]   RECIP    = RECIP_WIDE[KW:0];
  localparam logic [AW-1:0] DEPTH_LO = AW'(TABLE_DEPTH);

  typedef enum logic [1:0] {F_IDLE, F_QUOT, F_REM, F_DONE} fstate_t;

  fstate_t                       state;
  logic                          cmd;
  logic [KW-1:0]                 key;
  logic [pkpt_pkg::HANDLE_W-1:0] handle;
  logic [AW-1:0]                 quot_lo;
  logic [AW-1:0]                 rem;
  logic [2*KW:0]                 prod;
  logic [AW-1:0]                 back_lo;
  logic                          accept;

  // The operands are KW and KW + 1 bits wide; the cast only sizes the product.
  assign prod       = (2*KW + 1)'(key) * (2*KW + 1)'(RECIP);
  // The remainder is below the depth, so the low AW bits of the product suffice.
  assign back_lo    = quot_lo * DEPTH_LO;
  assign req.ready  = !clear_busy && ((state == F_IDLE) || ((state == F_DONE) && push_ready));
  assign accept     = req.valid && req.ready;
  assign push_valid = (state == F_DONE);
  assign push_data  = {cmd, key, handle, rem};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      if (accept) begin
        state  <= F_QUOT;
        cmd    <= req.command;
        key    <= req.key;
        handle <= req.handle;
      end else begin
        case (state)
          F_IDLE: begin
          end
          F_QUOT: begin
            quot_lo <= prod[RSH +: AW];
            state   <= F_REM;
          end
          F_REM: begin
            rem   <= key[AW-1:0] - back_lo;
            state <= F_DONE;
          end
          F_DONE: begin
            if (push_ready) begin
              state <= F_IDLE;
            end
          end
          default: begin
            state <= F_IDLE;
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pkpt_back.sv =====
// Back part: clears the tags, walks the probe sequence and holds the result.
`default_nettype none
`include "pid_keyed_probe_table_unit_defines.svh"
module pkpt_back #(
  parameter int TABLE_DEPTH = pkpt_pkg::DEF_TABLE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_valid,
  output logic       q_pop,
  input  wire logic [1 + pkpt_pkg::KEY_W + pkpt_pkg::HANDLE_W + $clog2(TABLE_DEPTH) - 1:0]
                     q_data,
  output logic       clear_busy,
  pkpt_rsp_if.source rsp
);

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int KW  = pkpt_pkg::KEY_W;
  localparam int HW  = pkpt_pkg::HANDLE_W;
  localparam int EW  = pkpt_pkg::ENTRY_W;
  localparam int SIW = pkpt_pkg::SLOT_IDX_W;
  localparam int QW  = 1 + KW + HW + AW;
  localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_PROBE} bstate_t;

  bstate_t                         state;
  logic [AW-1:0]                   clr_addr;
  logic [AW-1:0]                   cur;
  logic [AW-1:0]                   cnt;
  logic                            is_bind;
  logic [KW-1:0]                   cur_key;
  logic [HW-1:0]                   cur_handle;
  logic                            out_valid;
  logic [pkpt_pkg::STATUS_W-1:0]   out_status;
  logic [HW-1:0]                   out_handle;
  logic [SIW-1:0]                  out_slot;

  logic [EW-1:0]                   rdata;
  logic [EW-1:0]                   wdata;
  logic [AW-1:0]                   waddr;
  logic [AW-1:0]                   raddr;
  logic                            we;
  logic [pkpt_pkg::TAG_W-1:0]      tag;
  logic [KW-1:0]                   slot_key;
  logic [HW-1:0]                   slot_handle;
  logic [pkpt_pkg::TAG_W-1:0]      new_tag;
  logic [AW-1:0]                   nxt;
  logic                            match;
  logic                            hit;
  logic                            finish;
  logic                            res_load;
  logic [pkpt_pkg::STATUS_W-1:0]   status_next;

  always_comb begin
    tag         = rdata[EW-1 -: pkpt_pkg::TAG_W];
    slot_key    = rdata[HW +: KW];
    slot_handle = rdata[HW-1:0];
    match       = (tag == pkpt_pkg::TAG_LIVE) && (slot_key == cur_key);
    // A bind takes a matching live slot or any slot that is not live.
    hit         = is_bind ? (match || (tag != pkpt_pkg::TAG_LIVE)) : match;
    finish      = hit || (!is_bind && (tag == pkpt_pkg::TAG_EMPTY)) || (cnt == LAST);
    res_load    = (state == S_PROBE) && finish;
    nxt         = (cur == LAST) ? '0 : cur + 1'b1;
    new_tag     = (cur_handle == '0) ? pkpt_pkg::TAG_TOMB : pkpt_pkg::TAG_LIVE;
    if (hit) begin
      status_next = pkpt_pkg::ST_OK;
    end else if (is_bind) begin
      status_next = pkpt_pkg::ST_FULL;
    end else begin
      status_next = pkpt_pkg::ST_NOT_FOUND;
    end
    clear_busy = (state == S_CLEAR);
    q_pop      = (state == S_IDLE) && q_valid && (!out_valid || rsp.ready);
    raddr      = (state == S_PROBE) ? nxt : q_data[AW-1:0];
    we         = clear_busy || (res_load && hit && is_bind);
    waddr      = clear_busy ? clr_addr : cur;
    wdata      = clear_busy ? {pkpt_pkg::TAG_EMPTY, (KW + HW)'(0)}
                            : {new_tag, cur_key, cur_handle};
  end

  pkpt_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.found_handle = out_handle;
  assign rsp.slot_index   = out_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            state      <= S_PROBE;
            is_bind    <= (q_data[QW-1] == pkpt_pkg::CMD_BIND);
            cur_key    <= q_data[QW-2 -: KW];
            cur_handle <= q_data[AW +: HW];
            cur        <= q_data[AW-1:0];
            cnt        <= '0;
          end
        end
        S_PROBE: begin
          if (finish) begin
            state      <= S_IDLE;
            out_valid  <= 1'b1;
            out_status <= status_next;
            out_handle <= (hit && !is_bind) ? slot_handle : '0;
            out_slot   <= hit ? SIW'(cur) : '0;
          end else begin
            cur <= nxt;
            cnt <= cnt + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PKPT_ASSERT_IMPL(a_load_into_free, res_load, !out_valid, "result overwrites a pending one")
  `PKPT_ASSERT_IMPL(a_no_pop_in_clear, clear_busy, !q_pop, "queue popped during clearing")
  `PKPT_ASSERT_IMPL(a_full_after_walk, res_load && (status_next == pkpt_pkg::ST_FULL), cnt == LAST, "full reported before every slot was visited")
  `PKPT_ASSERT_NEXT(a_clear_ends, (state == S_CLEAR) && (clr_addr == LAST), state == S_IDLE, "clearing pass did not end")

endmodule
`default_nettype wire

// ===== hw/rtl/pid_keyed_probe_table_unit.sv =====
// Top level of the key-to-handle probe table with linear probing.
// The front reduces each key through capture, quotient and remainder steps;
// the back reads one slot per cycle from the RAM.
// Reset: synchronous; afterward a clearing pass over every slot runs with ready low.
`default_nettype none
module pid_keyed_probe_table_unit #(
  parameter int TABLE_DEPTH = pkpt_pkg::DEF_TABLE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  pkpt_req_if.sink   req,
  pkpt_rsp_if.source rsp
);

  // Width of one queued transaction: command, key, handle and the home slot.
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int QW = 1 + pkpt_pkg::KEY_W + pkpt_pkg::HANDLE_W + AW;

  logic          push_valid;
  logic          push_ready;
  logic [QW-1:0] push_data;
  logic          q_valid;
  logic          q_pop;
  logic [QW-1:0] q_data;
  logic          clear_busy;

  // The front accepts a request and computes key mod TABLE_DEPTH by a
  // reciprocal multiplication: state F_QUOT forms the quotient, and F_REM then
  // subtracts quotient times depth from the key. It holds the request off
  // while the back is still clearing the slot tags after reset.
  pkpt_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .clear_busy (clear_busy),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // A short queue decouples the two halves, so the front can reduce the next
  // key while the back is still walking the table for the current one.
  pkpt_fifo #(
    .WIDTH (QW),
    .DEPTH (pkpt_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_data   (push_data),
    .out_valid (q_valid),
    .out_ready (q_pop),
    .out_data  (q_data)
  );

  // The back owns the slot RAM. It reads one slot per cycle starting at the
  // home slot and wrapping at the end of the table. A lookup stops at a live
  // key match or at an empty slot, and steps over tombstones. A bind claims
  // the first slot that is not live or holds the same key; binding handle zero
  // leaves a tombstone there. After every slot has been visited, the result is
  // not found or table full. The response register lets the back take the next
  // queued transaction in the same cycle in which the current result is taken.
  pkpt_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_data     (q_data),
    .clear_busy (clear_busy),
    .rsp        (rsp)
  );

endmodule
`default_nettype wire

// ===== test/tb_pid_keyed_probe_table_unit.sv =====
// Testbench of the probe table: directed and random traffic checked against a behavioral table.
`timescale 1ns / 1ps

module tb_pid_keyed_probe_table_unit;
  import pkpt_pkg::*;

  localparam int DEPTH        = DEF_TABLE_DEPTH;
  // The longest correct quiet stretch is the clearing pass after reset, or a
  // long probe walk while the receiver holds off. The limit is many times that.
  localparam int IDLE_LIMIT   = 20000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int POOL_SIZE    = 24;
  localparam int CHAIN_LEN    = 48;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [HANDLE_W-1:0]   found_handle;
    logic [SLOT_IDX_W-1:0] slot_index;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #10 clk = ~clk;

  pkpt_req_if req();
  pkpt_rsp_if rsp();

  pid_keyed_probe_table_unit #(
    .TABLE_DEPTH(DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // Shadow copy of the table. Tags start empty; keys and handles are only
  // ever read from live slots, which have always been written first.
  logic [TAG_W-1:0]    tag_mem    [DEPTH];
  logic [KEY_W-1:0]    key_mem    [DEPTH];
  logic [HANDLE_W-1:0] handle_mem [DEPTH];

  // Answers still owed by the block, oldest first.
  answer_t answer_q[$];

  logic [KEY_W-1:0] key_pool[POOL_SIZE];

  int errors      = 0;
  int idle_cycles = 0;
  int n_lookup    = 0;
  int n_hit       = 0;
  int n_miss      = 0;
  int n_bind      = 0;
  int n_tomb      = 0;
  int n_full      = 0;
  int n_checked   = 0;

  // Sender and receiver pacing, changed from one test to the next.
  int gap_max    = 0;
  int burst_left = 0;
  int stall_pct  = 0;
  int hold_cnt   = 0;

  // Walks the shadow table exactly as the block walks its RAM: start at the
  // key's home slot, step by one with wrap, and visit at most every slot once.
  // A bind updates the shadow table as it goes, so the call order must match
  // the order in which the block accepts transactions.
  function automatic answer_t probe_table(input logic cmd, input logic [KEY_W-1:0] k,
                                          input logic [HANDLE_W-1:0] h);
    answer_t a;
    int      s;
    bit      hit;
    a.status       = (cmd == CMD_LOOKUP) ? ST_NOT_FOUND : ST_FULL;
    a.found_handle = '0;
    a.slot_index   = '0;
    for (int n = 0; n < DEPTH; n++) begin
      s   = (int'(k % DEPTH) + n) % DEPTH;
      hit = (tag_mem[s] == TAG_LIVE) && (key_mem[s] == k);
      if (cmd == CMD_LOOKUP) begin
        // Tombstones are stepped over; an empty slot ends the search.
        if (hit) begin
          a.status       = ST_OK;
          a.found_handle = handle_mem[s];
          a.slot_index   = s[SLOT_IDX_W-1:0];
          return a;
        end
        if (tag_mem[s] == TAG_EMPTY) return a;
      end else if (hit || tag_mem[s] != TAG_LIVE) begin
        // The first reusable slot wins, even when a live copy of the key
        // sits further along the chain. A zero handle leaves a tombstone.
        key_mem[s]     = k;
        handle_mem[s]  = h;
        tag_mem[s]     = (h == '0) ? TAG_TOMB : TAG_LIVE;
        a.status       = ST_OK;
        a.slot_index   = s[SLOT_IDX_W-1:0];
        return a;
      end
    end
    return a;
  endfunction

  // Scoreboard. Every accepted request gets its answer predicted at the same
  // edge, and every accepted response is compared with the oldest answer.
  // The watchdog shares this process because it needs both acceptances.
  always @(posedge clk) begin
    answer_t want;
    if (!rst) begin
      if (req.valid && req.ready) begin
        want = probe_table(req.command, req.key, req.handle);
        answer_q.push_back(want);
        if (req.command == CMD_LOOKUP) begin
          n_lookup++;
          if (want.status == ST_OK) n_hit++;
          else n_miss++;
        end else begin
          n_bind++;
          if (want.status == ST_FULL) n_full++;
          else if (req.handle == '0) n_tomb++;
        end
      end
      if (rsp.valid && rsp.ready) begin
        if (answer_q.size() == 0) begin
          $error("response with nothing outstanding: status %0d handle %h slot %0d",
                 rsp.status, rsp.found_handle, rsp.slot_index);
          errors++;
        end else begin
          want = answer_q.pop_front();
          n_checked++;
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            errors++;
          end
          if (rsp.found_handle !== want.found_handle) begin
            $error("found_handle: expected %h, got %h", want.found_handle, rsp.found_handle);
            errors++;
          end
          if (rsp.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, got %0d", want.slot_index, rsp.slot_index);
            errors++;
          end
        end
      end
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles, %0d answers outstanding.",
                 IDLE_LIMIT, answer_q.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Receiver. A long hold-off, when requested, takes priority; otherwise the
  // ready line drops at random with the current stall percentage.
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      rsp.ready = 1'b0;
      hold_cnt--;
    end else begin
      rsp.ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Offers one request and waits for the edge where it is accepted. Valid
  // stays high while a burst lasts; at the end of a burst the sender goes
  // quiet for a random number of cycles.
  task automatic send_item(input logic cmd, input logic [KEY_W-1:0] k,
                           input logic [HANDLE_W-1:0] h);
    @(negedge clk);
    req.valid   = 1'b1;
    req.command = cmd;
    req.key     = k;
    req.handle  = h;
    do @(posedge clk); while (!req.ready);
    if (gap_max == 0 || burst_left > 0) begin
      if (burst_left > 0) burst_left--;
    end else begin
      @(negedge clk);
      req.valid = 1'b0;
      repeat ($urandom_range(0, gap_max)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
  endtask

  // Stops offering and waits until every predicted answer has come back.
  task automatic wait_drain();
    @(negedge clk);
    req.valid = 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
  endtask

  // Keys that pile up on a few home slots, one cluster right at the top of
  // the table so that chains wrap to slot 0.
  task automatic make_key_pool();
    int base[4];
    base[0] = DEPTH - 2;
    for (int i = 1; i < 4; i++) base[i] = $urandom_range(0, DEPTH - 3);
    for (int i = 0; i < POOL_SIZE; i++)
      key_pool[i] = KEY_W'(base[$urandom_range(0, 3)] + $urandom_range(0, 2)
                           + DEPTH * $urandom_range(0, (1 << 21) - 1));
  endtask

  task automatic random_item();
    logic                cmd;
    logic [KEY_W-1:0]    k;
    logic [HANDLE_W-1:0] h;
    int                  r;
    cmd = $urandom_range(0, 1) ? CMD_BIND : CMD_LOOKUP;
    r   = $urandom_range(0, 99);
    if (r < 80)      k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    else if (r < 82) k = '0;
    else if (r < 84) k = '1;
    else             k = KEY_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 25)      h = '0;
    else if (r < 30) h = '1;
    else             h = $urandom;
    send_item(cmd, k, h);
  endtask

  task automatic do_reset();
    req.valid   = 1'b0;
    req.command = CMD_LOOKUP;
    req.key     = '0;
    req.handle  = '0;
    for (int i = 0; i < DEPTH; i++) tag_mem[i] = TAG_EMPTY;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  endtask

  // Corner cases by hand: misses on an empty table, key zero, the largest key
  // and handle, a chain that wraps from the last slot to slot 0, a bind that
  // reuses a tombstone ahead of a live copy, and a lookup that then finds the
  // stale live copy once the earlier one is tombstoned.
  task automatic test_directed_corners();
    stall_pct = 20;
    gap_max   = 4;
    send_item(CMD_LOOKUP, 31'd5,           32'h0000_0000);
    send_item(CMD_LOOKUP, 31'd0,           32'hFFFF_FFFF);
    send_item(CMD_BIND,   31'd0,           32'hFFFF_FFFF);
    send_item(CMD_LOOKUP, 31'd0,           32'h0000_0000);
    send_item(CMD_BIND,   31'h7FFF_FFFF,   32'h0000_0001);
    send_item(CMD_BIND,   31'd2047,        32'h1234_5678);
    send_item(CMD_LOOKUP, 31'd2047,        32'h0000_0000);
    send_item(CMD_LOOKUP, 31'h7FFF_FFFF,   32'h0000_0000);
    send_item(CMD_BIND,   31'h7FFF_FFFF,   32'h0000_0000);
    send_item(CMD_LOOKUP, 31'h7FFF_FFFF,   32'h0000_0000);
    send_item(CMD_BIND,   31'd2047,        32'hAAAA_5555);
    send_item(CMD_LOOKUP, 31'd2047,        32'h0000_0000);
    send_item(CMD_BIND,   31'd2047,        32'h0000_0000);
    send_item(CMD_LOOKUP, 31'd2047,        32'h0000_0000);
    send_item(CMD_BIND,   31'h5555_5555,   32'h8000_0001);
    send_item(CMD_LOOKUP, 31'h2AAA_AAAA,   32'h5555_AAAA);
    send_item(CMD_BIND,   31'd1024,        32'h5555_AAAA);
    send_item(CMD_LOOKUP, 31'd1024,        32'h0000_0000);
    wait_drain();
  endtask

  task automatic test_random_traffic(input int count, input int stall, input int gap);
    stall_pct = stall;
    gap_max   = gap;
    make_key_pool();
    repeat (count) random_item();
  endtask

  // The receiver holds off long enough for the block's internal queue to fill
  // and its request ready to drop, while the sender keeps offering back to back.
  task automatic test_backpressure();
    stall_pct = 0;
    gap_max   = 0;
    @(posedge clk);
    hold_cnt = HOLD_CYCLES;
    repeat (16) random_item();
    wait_drain();
  endtask

  // Many keys share one home slot near the top of the table, so the chain
  // wraps past slot 0 and the walks grow long. A key in the middle is then
  // tombstoned, looked up past, and its slot reused by a new key.
  task automatic test_long_chain();
    int               home;
    logic [KEY_W-1:0] chain_key[CHAIN_LEN];
    logic [KEY_W-1:0] fresh_key;
    stall_pct = 15;
    gap_max   = 3;
    home      = DEPTH - 8;
    for (int i = 0; i < CHAIN_LEN; i++) begin
      chain_key[i] = KEY_W'(home + DEPTH * $urandom_range(1, 1 << 20));
      send_item(CMD_BIND, chain_key[i], $urandom | 32'd1);
    end
    fresh_key = KEY_W'(home + DEPTH * $urandom_range(1, 1 << 20));
    send_item(CMD_LOOKUP, fresh_key,                32'h0000_0000);
    send_item(CMD_LOOKUP, chain_key[CHAIN_LEN - 1], 32'h0000_0000);
    send_item(CMD_BIND,   chain_key[CHAIN_LEN / 2], 32'h0000_0000);
    send_item(CMD_LOOKUP, chain_key[CHAIN_LEN / 2], 32'h0000_0000);
    send_item(CMD_LOOKUP, chain_key[CHAIN_LEN - 1], 32'h0000_0000);
    send_item(CMD_BIND,   fresh_key,                32'hDEAD_0001);
    send_item(CMD_LOOKUP, fresh_key,                32'h0000_0000);
    send_item(CMD_BIND,   chain_key[0],             32'hFFFF_FFFF);
    send_item(CMD_LOOKUP, chain_key[0],             32'h0000_0000);
    wait_drain();
  endtask

  initial begin
    do_reset();
    test_directed_corners();
    // No stalls and no gaps first, then growing pressure from both sides.
    test_random_traffic(120, 0, 0);
    test_random_traffic(160, 30, 6);
    test_backpressure();
    test_random_traffic(120, 70, 3);
    test_long_chain();
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (answer_q.size() != 0) begin
      $error("%0d answers never arrived", answer_q.size());
      errors++;
    end
    $display("Covered %0d lookups (%0d found, %0d missed) and %0d binds (%0d tombstones).",
             n_lookup, n_hit, n_miss, n_bind, n_tomb);
    $display("%0d binds hit a full table; %0d responses compared, %0d mismatches.",
             n_full, n_checked, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
